/* rtl/core/address_range_binary_search_core_defines.svh */
// ----------------------------------------------------------------------------
// Address range binary search - assertion macros
// Shared concurrent assertion wrappers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_BINARY_SEARCH_CORE_DEFINES_SVH
`define ADDRESS_RANGE_BINARY_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every clock edge out of reset
`define ARBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ARBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ARBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ARBS_ASSERT(lbl, prop, msg)
`define ARBS_ASSERT_IMP(lbl, ante, cons, msg)
`define ARBS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/arbs_pkg.sv */
// ----------------------------------------------------------------------------
// Address range binary search - package
// Sizes, codes and shared types of the range table and its search engine.
// ----------------------------------------------------------------------------
package arbs_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int TAG_BITS      = 16;

    localparam int ADDR_W        = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int IN_TAG_W      = 16;
    localparam int MATCH_IDX_W   = 12;
    localparam int MATCH_TAG_W   = 16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT       = 2'd0,
        ST_MISS      = 2'd1,
        ST_LOAD_OK   = 2'd2,
        ST_LOAD_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0]   rng_begin;
        logic [ADDR_W-1:0]   rng_end;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                op;
        logic [ADDR_W-1:0]   range_begin;
        logic [ADDR_W-1:0]   range_end;
        logic [IN_TAG_W-1:0] region_tag;
        logic [ADDR_W-1:0]   query_addr;
    } t_item;

    typedef struct packed {
        t_status                status;
        logic [MATCH_IDX_W-1:0] match_index;
        logic [MATCH_TAG_W-1:0] match_tag;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } t_ram_req;

endpackage

/* rtl/core/address_range_binary_search_core.sv */
// ----------------------------------------------------------------------------
// Address range binary search core
// Table of address ranges with append loads and binary-search lookups.
// ----------------------------------------------------------------------------
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+------------------------------------------------
//  input    | i_valid | o_stall | i_op, i_range_begin, i_range_end, i_region_tag,
//           |         |         | i_query_addr
//  output   | o_valid | i_stall | o_status, o_match_index, o_match_tag
//
//  A lookup takes P probes, P at most floor(log2(entries loaded)) + 1,
//  so up to 13 for a full 4096-entry table; the table RAM's single read
//  port allows one probe per cycle. A load writes the table when accepted.
//  A result goes to the output register; while that register is held by
//  i_stall a finished result waits and o_stall stays high.
//  Reset clears the entry count; table contents are not cleared.
// ----------------------------------------------------------------------------
module address_range_binary_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_range_begin,
    input  logic [31:0] i_range_end,
    input  logic [15:0] i_region_tag,
    input  logic [31:0] i_query_addr,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_match_index,
    output logic [15:0] o_match_tag
);

    import arbs_pkg::*;

    t_item               item;
    t_result             res;
    t_ram_req            ram;
    logic                res_valid;
    logic                out_free;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                r_out_valid;
    t_result             r_out;

    assign item = '{op:          i_op,
                    range_begin: i_range_begin,
                    range_end:   i_range_end,
                    region_tag:  i_region_tag,
                    query_addr:  i_query_addr};

    assign out_free = !r_out_valid || !i_stall;

    arbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (item),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram       (ram),
        .i_ram_rdata (ram_rdata)
    );

    arbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_raddr (ram.raddr),
        .o_rdata (ram_rdata)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_match_index = r_out.match_index;
    assign o_match_tag   = r_out.match_tag;

endmodule

/* rtl/core/arbs_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module arbs_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/arbs_ctrl.sv */
// ----------------------------------------------------------------------------
// Address range binary search - controller
// Appends ranges to the table and walks the binary search, one probe a cycle.
// ----------------------------------------------------------------------------
`include "address_range_binary_search_core_defines.svh"

module arbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  arbs_pkg::t_item   i_item,
    input  logic              i_out_free,
    output logic              o_res_valid,
    output arbs_pkg::t_result o_res,
    output arbs_pkg::t_ram_req o_ram,
    input  logic [arbs_pkg::ENTRY_W-1:0] i_ram_rdata
);

    import arbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hix, n_hix;     // exclusive upper bound
    logic [IDX_W-1:0]    r_mid, n_mid;
    logic [ADDR_W-1:0]   r_query, n_query;
    t_result             r_res, n_res;

    t_entry              ent;
    t_result             res;
    t_ram_req            ram;
    logic                res_valid;
    logic                lt, gt, hit, has_room;
    logic [CNT_W-1:0]    mid_ext, lo_s, hix_s, span_s, mid_s, init_span;

    always_comb begin
        ent       = t_entry'(i_ram_rdata);
        lt        = r_query < ent.rng_begin;
        gt        = r_query > ent.rng_end;
        hit       = !lt && !gt;
        mid_ext   = CNT_W'(r_mid);
        // below begin wins over above end when an entry has begin above end
        lo_s      = (gt && !lt) ? (mid_ext + 1'b1) : r_lo;
        hix_s     = lt ? mid_ext : r_hix;
        span_s    = hix_s - lo_s - 1'b1;
        mid_s     = lo_s + (span_s >> 1);
        init_span = r_count - 1'b1;
        has_room  = r_count < CNT_W'(TABLE_ENTRIES);

        res       = '{status: ST_MISS, match_index: '0, match_tag: '0};
        res_valid = 1'b0;
        ram.we    = 1'b0;
        ram.waddr = r_count[IDX_W-1:0];
        ram.wdata = {i_item.range_begin, i_item.range_end, TAG_BITS'(i_item.region_tag)};
        ram.raddr = init_span[IDX_W:1];

        n_state = r_state;
        n_count = r_count;
        n_lo    = r_lo;
        n_hix   = r_hix;
        n_mid   = r_mid;
        n_query = r_query;
        n_res   = r_res;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.op == OP_LOAD) begin
                        res_valid = 1'b1;
                        if (has_room) begin
                            ram.we     = 1'b1;
                            n_count    = r_count + 1'b1;
                            res.status = ST_LOAD_OK;
                        end else begin
                            res.status = ST_LOAD_FULL;
                        end
                    end else begin
                        n_query = i_item.query_addr;
                        n_lo    = '0;
                        n_hix   = r_count;
                        n_mid   = init_span[IDX_W:1];
                        if (r_count == '0) begin
                            res_valid = 1'b1;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH: begin
                // entry at r_mid is on the read port now; issue the next probe
                ram.raddr = mid_s[IDX_W-1:0];
                n_lo      = lo_s;
                n_hix     = hix_s;
                n_mid     = mid_s[IDX_W-1:0];
                if (hit || (lo_s >= hix_s)) begin
                    res_valid = 1'b1;
                    if (hit) begin
                        res.status      = ST_HIT;
                        res.match_index = MATCH_IDX_W'(r_mid);
                        res.match_tag   = MATCH_TAG_W'(ent.tag);
                    end
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                res       = r_res;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_valid) begin
            n_res   = res;
            n_state = i_out_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_lo    <= n_lo;
        r_hix   <= n_hix;
        r_mid   <= n_mid;
        r_query <= n_query;
        r_res   <= n_res;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_res_valid = res_valid;
    assign o_res       = res;
    assign o_ram       = ram;

    `ARBS_ASSERT(a_count_bound, r_count <= CNT_W'(TABLE_ENTRIES), "entry count beyond table size")
    `ARBS_ASSERT_IMP(a_window, r_state == S_SEARCH, (r_lo < r_hix) && (r_hix <= r_count), "search window empty or past loaded entries")
    `ARBS_ASSERT_IMP(a_mid_in_window, r_state == S_SEARCH, (mid_ext >= r_lo) && (mid_ext < r_hix), "probe index outside search window")
    `ARBS_ASSERT_NXT(a_load_count, (r_state == S_IDLE) && i_valid && (i_item.op == OP_LOAD) && has_room, r_count == $past(r_count) + 1'b1, "accepted load did not advance entry count")

endmodule
